// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rstn, cond, msg)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- design/pli_pkg.sv -----
// Shared types, codes and widths of the positional list engine.
package pli_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int CAPACITY_MAX = 64;
    localparam int IDX_MAX_W    = $clog2(CAPACITY_MAX);
    localparam int DATA_W       = 32;
    localparam int POS_W        = 6;
    localparam int CMD_W        = 3;
    localparam int ST_W         = 2;

    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_END   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_TRAVERSE  = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   idx;
        logic [IDX_MAX_W-1:0]   len_m1;
    } cell_ctrl_t;

endpackage

// ----- design/pli_cell.sv -----
// One storage cell of the list chain: holds one value and shifts with its neighbors.
module pli_cell #(
    parameter int CELL_ID = 0,
    parameter int IDX_W   = 5
) (
    input  logic                        aclk,
    input  pli_pkg::cell_ctrl_t         ctrl,
    input  logic [pli_pkg::DATA_W-1:0]  ins_value,
    input  logic [pli_pkg::DATA_W-1:0]  head_value,
    input  logic [pli_pkg::DATA_W-1:0]  left_value,
    input  logic [pli_pkg::DATA_W-1:0]  right_value,
    output logic [pli_pkg::DATA_W-1:0]  value
);

    localparam logic [IDX_W-1:0] MY_ID = IDX_W'(CELL_ID);

    logic [pli_pkg::DATA_W-1:0] value_reg;
    logic [pli_pkg::DATA_W-1:0] value_next;
    logic [IDX_W-1:0]           idx;
    logic [IDX_W-1:0]           len_m1;

    assign idx    = ctrl.idx[IDX_W-1:0];
    assign len_m1 = ctrl.len_m1[IDX_W-1:0];

    always_comb begin
        value_next = value_reg;
        case (ctrl.op)
            pli_pkg::CELL_INS: begin
                // open a gap at idx: cells above take their left neighbor
                if (MY_ID > idx) begin
                    value_next = left_value;
                end else if (MY_ID == idx) begin
                    value_next = ins_value;
                end
            end
            pli_pkg::CELL_DEL: begin
                if (MY_ID >= idx) begin
                    value_next = right_value;
                end
            end
            pli_pkg::CELL_ROT: begin
                // rotate toward the front; the tail cell takes the old head
                if (MY_ID == len_m1) begin
                    value_next = head_value;
                end else if (MY_ID < len_m1) begin
                    value_next = right_value;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- design/positional_list_engine.sv -----
// Top level of the positional list engine: command decode, cell chain and result register.
//
// Usage:
//   Input words arrive on the input channel (s_tvalid/s_tready/s_tdata/s_tuser). s_tuser
//   carries the command; s_tdata carries the value to insert and the 1-based position.
//   Results leave on the result channel (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast).
//   m_tuser carries the status, m_tdata the list element, m_tlast marks the final
//   result word of a command.
//   For edit commands (insert/delete) the word is accepted, every cell shifts at once,
//   and the status word is valid in the next cycle.
//   A traverse of N stored values holds the input from the accept cycle through one
//   step per value, each copying the head cell to the result register while
//   the chain rotates one place toward the front; after N steps the list is back in
//   order. Receiver stalls delay the steps. Sustained rate is one edit per cycle while
//   each result word is taken. A result register sits between the chain and the result
//   channel; a new edit is accepted whenever no traverse runs and that register is empty
//   or its word is taken in the same cycle. When the receiver stalls, the result word
//   holds and s_tready drops. Command 7 is accepted and dropped without a result.
//   Reset (aresetn low, synchronous) empties the list and the result register;
//   the stored values themselves are not cleared.
module positional_list_engine #(
    parameter int CAPACITY = pli_pkg::CAPACITY_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [37:32] position, [39:38] zero
    input  logic [2:0]  s_tuser,   // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] element
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int LENW  = $clog2(CAPACITY + 1);
    localparam int CMPW  = ((LENW > pli_pkg::POS_W) ? LENW : pli_pkg::POS_W) + 1;
    localparam logic [LENW-1:0] FULL_LEN = LENW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TRAV = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [LENW-1:0] len_reg, len_next;
    logic [LENW-1:0] cnt_reg, cnt_next;

    logic                        m_valid_reg;
    logic [pli_pkg::ST_W-1:0]    m_status_reg;
    logic [pli_pkg::DATA_W-1:0]  m_elem_reg;
    logic                        m_last_reg;

    // input fields
    logic [pli_pkg::CMD_W-1:0]   s_cmd;
    logic [pli_pkg::DATA_W-1:0]  s_value;
    logic [pli_pkg::POS_W-1:0]   s_pos;

    assign s_cmd   = s_tuser[pli_pkg::CMD_W-1:0];
    assign s_value = s_tdata[31:0];
    assign s_pos   = s_tdata[37:32];

    logic out_free;
    logic s_fire;
    logic trav_step;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign trav_step = (state_reg == ST_TRAV) && out_free;

    // command decode
    logic [CMPW-1:0]           pos_ext;
    logic [CMPW-1:0]           len_ext;
    logic [CMPW-1:0]           pos_m1;
    logic [LENW-1:0]           len_m1;
    logic                      is_full;
    logic                      is_empty;
    pli_pkg::cell_op_t         ed_op;
    logic [IDX_W-1:0]          ed_idx;
    logic [pli_pkg::ST_W-1:0]  ed_status;
    logic                      ed_emit;
    logic                      ed_trav;
    logic [LENW-1:0]           ed_len;

    assign pos_ext  = CMPW'(s_pos);
    assign len_ext  = CMPW'(len_reg);
    assign pos_m1   = pos_ext - 1'b1;
    assign len_m1   = len_reg - 1'b1;
    assign is_full  = (len_reg == FULL_LEN);
    assign is_empty = (len_reg == '0);

    always_comb begin
        ed_op     = pli_pkg::CELL_HOLD;
        ed_idx    = '0;
        ed_status = pli_pkg::ST_OK;
        ed_emit   = 1'b1;
        ed_trav   = 1'b0;
        ed_len    = len_reg;
        unique case (s_cmd)
            pli_pkg::CMD_INS_FRONT: begin
                if (is_full) begin
                    ed_status = pli_pkg::ST_FULL;
                end else begin
                    ed_op  = pli_pkg::CELL_INS;
                    ed_len = len_reg + 1'b1;
                end
            end
            pli_pkg::CMD_INS_POS: begin
                // range check before full check
                if (pos_ext == '0 || pos_ext > len_ext + 1'b1) begin
                    ed_status = pli_pkg::ST_RANGE;
                end else if (is_full) begin
                    ed_status = pli_pkg::ST_FULL;
                end else begin
                    ed_op  = pli_pkg::CELL_INS;
                    ed_idx = pos_m1[IDX_W-1:0];
                    ed_len = len_reg + 1'b1;
                end
            end
            pli_pkg::CMD_INS_END: begin
                if (is_full) begin
                    ed_status = pli_pkg::ST_FULL;
                end else begin
                    ed_op  = pli_pkg::CELL_INS;
                    ed_idx = len_reg[IDX_W-1:0];
                    ed_len = len_reg + 1'b1;
                end
            end
            pli_pkg::CMD_DEL_FRONT: begin
                if (is_empty) begin
                    ed_status = pli_pkg::ST_EMPTY;
                end else begin
                    ed_op  = pli_pkg::CELL_DEL;
                    ed_len = len_m1;
                end
            end
            pli_pkg::CMD_DEL_POS: begin
                if (is_empty) begin
                    ed_status = pli_pkg::ST_EMPTY;
                end else if (pos_ext == '0 || pos_ext > len_ext) begin
                    ed_status = pli_pkg::ST_RANGE;
                end else begin
                    ed_op  = pli_pkg::CELL_DEL;
                    ed_idx = pos_m1[IDX_W-1:0];
                    ed_len = len_m1;
                end
            end
            pli_pkg::CMD_DEL_END: begin
                if (is_empty) begin
                    ed_status = pli_pkg::ST_EMPTY;
                end else begin
                    ed_op  = pli_pkg::CELL_DEL;
                    ed_idx = len_m1[IDX_W-1:0];
                    ed_len = len_m1;
                end
            end
            pli_pkg::CMD_TRAVERSE: begin
                if (is_empty) begin
                    ed_status = pli_pkg::ST_EMPTY;
                end else begin
                    ed_emit = 1'b0;
                    ed_trav = 1'b1;
                end
            end
            default: begin
                // undefined command: drop silently
                ed_emit = 1'b0;
            end
        endcase
    end

    // cell chain
    pli_pkg::cell_ctrl_t         cell_ctrl;
    logic [pli_pkg::DATA_W-1:0]  cell_q [CAPACITY];
    logic [pli_pkg::DATA_W-1:0]  head_value;

    assign head_value = cell_q[0];

    always_comb begin
        cell_ctrl.op     = pli_pkg::CELL_HOLD;
        cell_ctrl.idx    = pli_pkg::IDX_MAX_W'(ed_idx);
        cell_ctrl.len_m1 = pli_pkg::IDX_MAX_W'(len_m1[IDX_W-1:0]);
        if (trav_step) begin
            cell_ctrl.op = pli_pkg::CELL_ROT;
        end else if (s_fire) begin
            cell_ctrl.op = ed_op;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [pli_pkg::DATA_W-1:0] left_v;
        logic [pli_pkg::DATA_W-1:0] right_v;
        if (g == 0) begin : g_first
            assign left_v = s_value;
        end else begin : g_mid_l
            assign left_v = cell_q[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_q[g];
        end else begin : g_mid_r
            assign right_v = cell_q[g+1];
        end
        pli_cell #(
            .CELL_ID (g),
            .IDX_W   (IDX_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (cell_ctrl),
            .ins_value   (s_value),
            .head_value  (head_value),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_q[g])
        );
    end

    // control: length, traverse state and counter
    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    len_next = ed_len;
                    cnt_next = '0;
                    if (ed_trav) begin
                        state_next = ST_TRAV;
                    end
                end
            end
            ST_TRAV: begin
                if (trav_step) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == len_m1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
        end
    end

    // result register: load on an edit, an empty-list traverse or a traverse step, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((s_fire && ed_emit) || trav_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (trav_step) begin
            m_status_reg <= pli_pkg::ST_OK;
            m_elem_reg   <= head_value;
            m_last_reg   <= (cnt_reg == len_m1);
        end else if (s_fire && ed_emit) begin
            m_status_reg <= ed_status;
            m_elem_reg   <= '0;
            m_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_elem_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_len_bound, aclk, aresetn, len_reg <= FULL_LEN,
        "length above capacity")
    `ASSERT_IMPLIES(a_trav_nonempty, aclk, aresetn, state_reg == ST_TRAV,
        !is_empty && cnt_reg <= len_m1, "traverse on empty list or counter overrun")
    `ASSERT_NEXT(a_ins_grows, aclk, aresetn, s_fire && ed_op == pli_pkg::CELL_INS,
        len_reg == $past(len_reg) + 1'b1, "insert did not grow the list")
    `ASSERT_NEXT(a_trav_end, aclk, aresetn, trav_step && cnt_reg == len_m1,
        state_reg == ST_IDLE && m_tlast, "traverse did not end on last word")

endmodule
